@@ sv/dsm_pkg.sv @@
// Shared constants and types for the differential steering mixer.
// Used by dsm_div_stage and differential_steering_mixer_core; no dependencies.
`default_nettype none

package dsm_pkg;

    localparam int AXIS_W     = 16;
    localparam int DRIVE_W    = 8;
    localparam int LIMIT_W    = 7;
    localparam int QUO_W      = 8;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 7'd32;
    localparam logic signed [8:0]  PREMIX_FULL  = 9'sd127;
    localparam logic [LIMIT_W-1:0] UNIT_DIVISOR = 7'd1;

    typedef struct packed {
        logic [LIMIT_W-1:0] rem;
        logic [QUO_W-1:0]   acc;
        logic               neg;
    } dsm_lane_t;

    typedef struct packed {
        dsm_lane_t          left;
        dsm_lane_t          right;
        logic [LIMIT_W-1:0] div;
    } dsm_div_t;

endpackage

`default_nettype wire

@@ sv/dsm_div_stage.sv @@
// One pipeline stage of the drive divider: two restoring steps on both lanes.
// Depends on dsm_pkg for the lane and stage payload types.
`default_nettype none

module dsm_div_stage (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire dsm_pkg::dsm_div_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output dsm_pkg::dsm_div_t    out_data
);
    import dsm_pkg::*;

    logic     valid_reg;
    dsm_div_t data_reg;
    dsm_div_t data_next;

    function automatic dsm_lane_t div_step(dsm_lane_t lane, logic [LIMIT_W-1:0] div);
        logic [LIMIT_W:0] trial;
        logic [LIMIT_W:0] diff;
        logic             ge;
        dsm_lane_t        res;
        trial   = {lane.rem, lane.acc[QUO_W-1]};
        diff    = trial - {1'b0, div};
        ge      = (trial >= {1'b0, div});
        res.rem = ge ? diff[LIMIT_W-1:0] : trial[LIMIT_W-1:0];
        res.acc = {lane.acc[QUO_W-2:0], ge};
        res.neg = lane.neg;
        return res;
    endfunction

    always_comb begin
        data_next       = in_data;
        data_next.left  = div_step(div_step(in_data.left, in_data.div), in_data.div);
        data_next.right = div_step(div_step(in_data.right, in_data.div), in_data.div);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            data_reg <= data_next;
        end
    end

`ifndef SYNTH
    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (data_reg.left.rem < data_reg.div) && (data_reg.right.rem < data_reg.div))
        else $error("divider remainder not below divisor");
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (data_reg.div != '0))
        else $error("divider stage holds zero divisor");
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !out_ready |=> valid_reg && $stable(data_reg))
        else $error("divider stage lost or changed a stalled request");
`endif

endmodule

`default_nettype wire

@@ sv/differential_steering_mixer_core.sv @@
// Differential steering mixer: one joystick sample in, left/right drive pair out.
// Accepts one sample per clock unless m_tready back-pressure fills the pipeline;
// each sample passes nine register stages: axis reduction, two multiply stages,
// magnitude, four divider stages of two quotient bits each, and the saturating
// output register. Every stage holds its request under back-pressure and fills bubbles,
// so input is taken while results wait. pivot_y_limit is written through
// cfg_wr_en/cfg_wr_data.
// Depends on dsm_pkg and dsm_div_stage.
`default_nettype none

module differential_steering_mixer_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [6:0]  cfg_wr_data,   // pivot_y_limit
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,       // [15:0] joy_x, [31:16] joy_y
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata        // [7:0] left_drive, [15:8] right_drive
);
    import dsm_pkg::*;

    logic [LIMIT_W-1:0] limit_reg;

    // stage 1: axis reduction and premix
    logic                      v1_reg;
    logic signed [7:0]         y1_reg, y1_next;
    logic signed [8:0]         xl1_reg, xl1_next;
    logic signed [8:0]         pl1_reg, pl1_next, pr1_reg, pr1_next;
    logic [7:0]                ay1_reg, ay1_next;
    logic                      blend1_reg, blend1_next;
    logic [LIMIT_W-1:0]        dl1_reg, dl1_next;
    logic [LIMIT_W-1:0]        lim1_reg;
    logic                      rdy1;

    // stage 2: first products
    logic                      v2_reg;
    logic signed [15:0]        pyl2_reg, pyl2_next, pyr2_reg, pyr2_next;
    logic signed [15:0]        pwl2_reg, pwl2_next, pwr2_reg, pwr2_next;
    logic [7:0]                ay2_reg;
    logic                      blend2_reg;
    logic [LIMIT_W-1:0]        lim2_reg;
    logic                      rdy2;

    // stage 3: numerators
    logic                      v3_reg;
    logic signed [23:0]        nl3_reg, nl3_next, nr3_reg, nr3_next;
    logic                      blend3_reg;
    logic [LIMIT_W-1:0]        lim3_reg;
    logic                      rdy3;

    // stage 4: magnitude, divide by 128, divider setup
    logic                      v4_reg;
    dsm_div_t                  d4_reg, d4_next;
    logic                      rdy4;

    logic                      dv [4];
    logic                      dr [4];
    dsm_div_t                  dd [4];

    logic                      vo_reg;
    logic [DRIVE_W-1:0]        lo_reg, lo_next, ro_reg, ro_next;
    logic                      rdyo;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    function automatic logic signed [7:0] axis_reduce(logic [AXIS_W-1:0] raw);
        logic signed [7:0] hi;
        hi = raw[15:8];
        if (raw[15] && (raw[7:0] != 8'd0)) begin
            hi = hi + 8'sd1;
        end
        return hi;
    endfunction

    function automatic logic [DRIVE_W-1:0] drive_out(dsm_lane_t lane);
        logic [DRIVE_W-1:0] res;
        if (lane.neg) begin
            res = ~lane.acc + 8'd1;
        end else if (lane.acc[QUO_W-1]) begin
            res = 8'h7F;
        end else begin
            res = lane.acc;
        end
        return res;
    endfunction

    always_comb begin
        logic signed [7:0] x, y;
        logic signed [8:0] xe;
        logic [7:0]        ay;
        logic [7:0]        diff;
        x    = axis_reduce(s_tdata[15:0]);
        y    = axis_reduce(s_tdata[31:16]);
        xe   = {x[7], x};
        ay   = y[7] ? (~y + 8'd1) : y;
        diff = {1'b0, limit_reg} - ay;
        if (!y[7]) begin
            pl1_next = x[7] ? PREMIX_FULL + xe : PREMIX_FULL;
            pr1_next = x[7] ? PREMIX_FULL : PREMIX_FULL - xe;
        end else begin
            pl1_next = x[7] ? PREMIX_FULL : PREMIX_FULL - xe;
            pr1_next = x[7] ? PREMIX_FULL + xe : PREMIX_FULL;
        end
        y1_next     = y;
        xl1_next    = xe;
        ay1_next    = ay;
        blend1_next = (limit_reg != '0) && (ay <= {1'b0, limit_reg});
        dl1_next    = diff[LIMIT_W-1:0];
    end

    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (rdy1) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            y1_reg     <= y1_next;
            xl1_reg    <= xl1_next;
            pl1_reg    <= pl1_next;
            pr1_reg    <= pr1_next;
            ay1_reg    <= ay1_next;
            blend1_reg <= blend1_next;
            dl1_reg    <= dl1_next;
            lim1_reg   <= limit_reg;
        end
    end

    always_comb begin
        logic signed [16:0] p_pyl, p_pyr, p_pwl, p_pwr;
        logic signed [7:0]  dls;
        logic signed [8:0]  xr;
        dls       = $signed({1'b0, dl1_reg});
        xr        = -xl1_reg;
        p_pyl     = pl1_reg * y1_reg;
        p_pyr     = pr1_reg * y1_reg;
        p_pwl     = dls * xl1_reg;
        p_pwr     = dls * xr;
        pyl2_next = p_pyl[15:0];
        pyr2_next = p_pyr[15:0];
        pwl2_next = p_pwl[15:0];
        pwr2_next = p_pwr[15:0];
    end

    assign rdy2 = !v2_reg || rdy3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (rdy2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            pyl2_reg   <= pyl2_next;
            pyr2_reg   <= pyr2_next;
            pwl2_reg   <= pwl2_next;
            pwr2_reg   <= pwr2_next;
            ay2_reg    <= ay1_reg;
            blend2_reg <= blend1_reg;
            lim2_reg   <= lim1_reg;
        end
    end

    always_comb begin
        logic signed [24:0] tl, tr;
        logic signed [8:0]  ays;
        ays = $signed({1'b0, ay2_reg});
        tl  = ays * pyl2_reg + (pwl2_reg <<< 7);
        tr  = ays * pyr2_reg + (pwr2_reg <<< 7);
        if (blend2_reg) begin
            nl3_next = tl[23:0];
            nr3_next = tr[23:0];
        end else begin
            nl3_next = {{8{pyl2_reg[15]}}, pyl2_reg};
            nr3_next = {{8{pyr2_reg[15]}}, pyr2_reg};
        end
    end

    assign rdy3 = !v3_reg || rdy4;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (rdy3) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            nl3_reg    <= nl3_next;
            nr3_reg    <= nr3_next;
            blend3_reg <= blend2_reg;
            lim3_reg   <= lim2_reg;
        end
    end

    always_comb begin
        logic [23:0] ml, mr;
        ml                = nl3_reg[23] ? (~nl3_reg + 24'd1) : nl3_reg;
        mr                = nr3_reg[23] ? (~nr3_reg + 24'd1) : nr3_reg;
        d4_next.left.rem  = ml[21:15];
        d4_next.left.acc  = ml[14:7];
        d4_next.left.neg  = nl3_reg[23];
        d4_next.right.rem = mr[21:15];
        d4_next.right.acc = mr[14:7];
        d4_next.right.neg = nr3_reg[23];
        d4_next.div       = blend3_reg ? lim3_reg : UNIT_DIVISOR;
    end

    assign rdy4 = !v4_reg || dr[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (rdy4) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            d4_reg <= d4_next;
        end
    end

    for (genvar i = 0; i < 4; i++) begin : g_div
        logic     up_valid;
        dsm_div_t up_data;
        logic     dn_ready;
        if (i == 0) begin : g_first
            assign up_valid = v4_reg;
            assign up_data  = d4_reg;
        end else begin : g_rest
            assign up_valid = dv[i-1];
            assign up_data  = dd[i-1];
        end
        if (i == 3) begin : g_last
            assign dn_ready = rdyo;
        end else begin : g_mid
            assign dn_ready = dr[i+1];
        end
        dsm_div_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (up_valid),
            .in_ready  (dr[i]),
            .in_data   (up_data),
            .out_valid (dv[i]),
            .out_ready (dn_ready),
            .out_data  (dd[i])
        );
    end

    assign lo_next = drive_out(dd[3].left);
    assign ro_next = drive_out(dd[3].right);
    assign rdyo    = !vo_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (rdyo) begin
            vo_reg <= dv[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdyo) begin
            lo_reg <= lo_next;
            ro_reg <= ro_next;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = {ro_reg, lo_reg};

`ifndef SYNTH
    a_blend_in_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && blend1_reg |-> (ay1_reg <= {1'b0, lim1_reg}) && (lim1_reg != '0))
        else $error("blend selected outside pivot limit");
    a_direct_small: assert property (@(posedge aclk) disable iff (!aresetn)
        v4_reg && (d4_reg.div == UNIT_DIVISOR) |->
        (d4_reg.left.rem == '0) && (d4_reg.right.rem == '0))
        else $error("unit-divisor drive magnitude out of range");
    a_quotient_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        dv[3] |-> (dd[3].left.acc <= 8'd128) && (dd[3].right.acc <= 8'd128))
        else $error("drive quotient exceeds saturation bound");
`endif

endmodule

`default_nettype wire
